@@ rtl/core/gtc_pkg.sv @@
// ----------------------------------------------------------------------------
// gtc_pkg
// Shared types, constants and bit-search helpers of the three-colour
// criticality classifier.
// ----------------------------------------------------------------------------
package gtc_pkg;

  localparam int unsigned NV = 32;           // vertices held in the store
  localparam int unsigned IW = $clog2(NV);   // vertex index width
  localparam int unsigned CW = 6;            // vertex_count register width
  localparam int unsigned NUM_COLORS = 3;

  localparam logic [1:0] CLASS_COLORABLE = 2'd0;
  localparam logic [1:0] CLASS_NOT_CRIT  = 2'd1;
  localparam logic [1:0] CLASS_EDGE_CRIT = 2'd2;
  localparam logic [1:0] CLASS_TARGET    = 2'd3;

  typedef logic [NV-1:0] vmask_t;

  typedef struct packed {
    logic          found;
    logic [IW-1:0] idx;
  } find_t;

  // Command to the colouring engine
  typedef struct packed {
    logic          start;
    vmask_t        live;
    logic          skip_en;
    logic [IW-1:0] lo;
    logic [IW-1:0] hi;
  } srch_cmd_t;

  // Status and row read request from the colouring engine
  typedef struct packed {
    logic          done;
    logic          colorable;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
  } srch_sts_t;

  function automatic vmask_t onehot(input logic [IW-1:0] v);
    vmask_t one;
    one = vmask_t'(1);
    return one << v;
  endfunction

  // Bits 0 .. v set
  function automatic vmask_t mask_le(input logic [IW-1:0] v);
    vmask_t sh;
    sh = onehot(v) << 1;
    return sh - vmask_t'(1);
  endfunction

  function automatic vmask_t live_mask(input logic [CW-1:0] vc);
    logic [CW:0] n;
    vmask_t      one;
    one = vmask_t'(1);
    n   = ({1'b0, vc} > (CW+1)'(NV)) ? (CW+1)'(NV) : {1'b0, vc};
    if (n >= (CW+1)'(NV)) begin
      return '1;
    end
    return (one << n) - one;
  endfunction

  // Lowest set bit
  function automatic find_t find_first(input vmask_t m);
    find_t r;
    r = '0;
    for (int i = NV - 1; i >= 0; i--) begin
      if (m[i]) begin
        r.found = 1'b1;
        r.idx   = IW'(i);
      end
    end
    return r;
  endfunction

  // Highest set bit
  function automatic find_t find_last(input vmask_t m);
    find_t r;
    r = '0;
    for (int i = 0; i < NV; i++) begin
      if (m[i]) begin
        r.found = 1'b1;
        r.idx   = IW'(i);
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/core/gtc_ram.sv @@
// ----------------------------------------------------------------------------
// gtc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gtc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/core/gtc_search.sv @@
// ----------------------------------------------------------------------------
// gtc_search
// Backtracking 3-colouring engine. Walks the live vertices in ascending
// order, fetching one adjacency row per visit from the shared store.
// ----------------------------------------------------------------------------
module gtc_search (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gtc_pkg::srch_cmd_t  cmd_i,
  input  gtc_pkg::vmask_t     row_i,
  output gtc_pkg::srch_sts_t  sts_o
);
  import gtc_pkg::*;

  typedef enum logic [3:0] {
    SE_IDLE = 4'b0001,
    SE_READ = 4'b0010,
    SE_EVAL = 4'b0100,
    SE_DONE = 4'b1000
  } se_state_e;

  se_state_e     state_q, state_d;
  vmask_t        live_q, live_d;
  logic          skip_q, skip_d;
  logic [IW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [IW-1:0] v_q, v_d;
  logic [1:0]    c0_q, c0_d;
  vmask_t        cm_q [NUM_COLORS];
  vmask_t        cm_d [NUM_COLORS];
  logic          res_q, res_d;

  vmask_t nb;
  logic   any_ok;
  logic [1:0] pick;
  logic [1:0] pc;
  find_t  nxt, prv, fst;

  always_comb begin
    nb = row_i & live_q & ~onehot(v_q);
    if (skip_q && v_q == lo_q) nb = nb & ~onehot(hi_q);
    if (skip_q && v_q == hi_q) nb = nb & ~onehot(lo_q);
    any_ok = 1'b0;
    pick   = 2'd0;
    for (int c = NUM_COLORS - 1; c >= 0; c--) begin
      if (((nb & cm_q[c]) == '0) && (2'(c) >= c0_q)) begin
        any_ok = 1'b1;
        pick   = 2'(c);
      end
    end
    nxt = find_first(live_q & ~mask_le(v_q));
    prv = find_last(live_q & mask_le(v_q) & ~onehot(v_q));
    fst = find_first(cmd_i.live);
    if (cm_q[0][prv.idx])      pc = 2'd0;
    else if (cm_q[1][prv.idx]) pc = 2'd1;
    else                       pc = 2'd2;
  end

  always_comb begin
    state_d = state_q;
    live_d  = live_q;
    skip_d  = skip_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    v_d     = v_q;
    c0_d    = c0_q;
    res_d   = res_q;
    for (int c = 0; c < NUM_COLORS; c++) cm_d[c] = cm_q[c];
    case (state_q)
      SE_IDLE: begin
        if (cmd_i.start) begin
          live_d = cmd_i.live;
          skip_d = cmd_i.skip_en;
          lo_d   = cmd_i.lo;
          hi_d   = cmd_i.hi;
          v_d    = fst.idx;
          c0_d   = 2'd0;
          for (int c = 0; c < NUM_COLORS; c++) cm_d[c] = '0;
          if (fst.found) begin
            state_d = SE_READ;
          end else begin
            res_d   = 1'b1;
            state_d = SE_DONE;
          end
        end
      end
      SE_READ: state_d = SE_EVAL;
      SE_EVAL: begin
        if (any_ok) begin
          cm_d[pick] = cm_q[pick] | onehot(v_q);
          if (nxt.found) begin
            v_d     = nxt.idx;
            c0_d    = 2'd0;
            state_d = SE_READ;
          end else begin
            res_d   = 1'b1;
            state_d = SE_DONE;
          end
        end else if (prv.found) begin
          // back up to the previous vertex and resume past its colour
          v_d      = prv.idx;
          cm_d[pc] = cm_q[pc] & ~onehot(prv.idx);
          c0_d     = pc + 2'd1;
          state_d  = SE_READ;
        end else begin
          res_d   = 1'b0;
          state_d = SE_DONE;
        end
      end
      SE_DONE: state_d = SE_IDLE;
      default: state_d = SE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SE_IDLE;
      res_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    live_q <= live_d;
    skip_q <= skip_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    v_q    <= v_d;
    c0_q   <= c0_d;
    for (int c = 0; c < NUM_COLORS; c++) cm_q[c] <= cm_d[c];
  end

  assign sts_o.done      = (state_q == SE_DONE);
  assign sts_o.colorable = res_q;
  assign sts_o.rd_en     = (state_q == SE_READ);
  assign sts_o.rd_addr   = v_q;

endmodule

@@ rtl/core/graph_three_color_criticality.sv @@
// ----------------------------------------------------------------------------
// graph_three_color_criticality
// Loads graph edges into an adjacency RAM and, on the last edge, classifies
// the graph by 3-colourability of the graph, its vertex and edge deletions.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------
//  edge in  | start_i & !busy_o     | vertex_a_i, vertex_b_i, last_edge_i
//  class out| done_o (one cycle)    | graph_class_o
//  config   | vertex_count_we_i     | vertex_count_i
//
//  An edge beat is a read-modify-write of both rows: row a, then row b.
//  A last-edge beat then runs up to 1 + n + n*(n-1)/2 searches; each reads
//  one row per vertex visit, and backtracking sets the visit count.
//  The vertex scan steps past skipped vertices in the deletion passes, reads
//  and scans the row of each live vertex in the edge pass, then ends in T_OUT.
//  Reset clears the row valid bits; the RAM itself is never swept.
//  busy_o holds off new edges throughout; the result cannot be stalled.
// ----------------------------------------------------------------------------
module graph_three_color_criticality (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [4:0]              vertex_a_i,
  input  logic [4:0]              vertex_b_i,
  input  logic                    last_edge_i,
  input  logic                    vertex_count_we_i,
  input  logic [gtc_pkg::CW-1:0]  vertex_count_i,
  output logic                    done_o,
  output logic [1:0]              graph_class_o
);
  import gtc_pkg::*;

  typedef enum logic [11:0] {
    T_IDLE   = 12'b000000000001,
    T_LD_A   = 12'b000000000010,
    T_LD_B   = 12'b000000000100,
    T_P0_GO  = 12'b000000001000,
    T_P0_WT  = 12'b000000010000,
    T_P1_SEL = 12'b000000100000,
    T_P1_WT  = 12'b000001000000,
    T_P2_RD  = 12'b000010000000,
    T_P2_LAT = 12'b000100000000,
    T_P2_SEL = 12'b001000000000,
    T_P2_WT  = 12'b010000000000,
    T_OUT    = 12'b100000000000
  } top_state_e;

  top_state_e    state_q, state_d;
  logic [CW-1:0] vc_q;
  vmask_t        valid_q, valid_d;
  logic          rd_vld_q;
  logic [IW-1:0] a_q, b_q, u_q, u_d, v_q, v_d;
  logic          last_q, inrange_q;
  logic [1:0]    class_q, class_d;
  vmask_t        nbr_q, nbr_d;

  logic          accept;
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  vmask_t        ram_wdata, ram_rdata, row;
  vmask_t        live;
  logic          u_last, v_last;

  srch_cmd_t     cmd;
  srch_sts_t     sts;

  assign accept = start_i && !busy_o;
  assign live   = live_mask(vc_q);
  assign row    = rd_vld_q ? ram_rdata : '0;
  assign u_last = (u_q == IW'(NV - 1));
  assign v_last = (v_q == IW'(NV - 1));

  gtc_ram #(.Width(NV), .Depth(NV)) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  gtc_search u_search (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .row_i  (row),
    .sts_o  (sts)
  );

  always_comb begin
    state_d   = state_q;
    valid_d   = valid_q;
    u_d       = u_q;
    v_d       = v_q;
    class_d   = class_q;
    nbr_d     = nbr_q;
    ram_we    = 1'b0;
    ram_waddr = a_q;
    ram_wdata = row | onehot(b_q);
    ram_re    = sts.rd_en;
    ram_raddr = sts.rd_addr;
    cmd       = '0;
    cmd.live  = live;
    case (state_q)
      T_IDLE: begin
        if (accept) begin
          // fetch row a while the beat is captured
          ram_re    = 1'b1;
          ram_raddr = vertex_a_i;
          state_d   = T_LD_A;
        end
      end
      T_LD_A: begin
        ram_we    = inrange_q;
        ram_waddr = a_q;
        ram_wdata = row | onehot(b_q);
        ram_re    = 1'b1;
        ram_raddr = b_q;
        if (inrange_q) valid_d[a_q] = 1'b1;
        state_d   = T_LD_B;
      end
      T_LD_B: begin
        ram_we    = inrange_q;
        ram_waddr = b_q;
        ram_wdata = row | onehot(a_q);
        if (inrange_q) valid_d[b_q] = 1'b1;
        state_d   = last_q ? T_P0_GO : T_IDLE;
      end
      T_P0_GO: begin
        cmd.start = 1'b1;
        state_d   = T_P0_WT;
      end
      T_P0_WT: begin
        if (sts.done) begin
          if (sts.colorable) begin
            class_d = CLASS_COLORABLE;
            state_d = T_OUT;
          end else begin
            u_d     = '0;
            state_d = T_P1_SEL;
          end
        end
      end
      T_P1_SEL: begin
        if (live[u_q]) begin
          cmd.start = 1'b1;
          cmd.live  = live & ~onehot(u_q);
          state_d   = T_P1_WT;
        end else if (u_last) begin
          u_d     = '0;
          state_d = T_P2_RD;
        end else begin
          u_d = u_q + IW'(1);
        end
      end
      T_P1_WT: begin
        if (sts.done) begin
          if (!sts.colorable) begin
            class_d = CLASS_NOT_CRIT;
            state_d = T_OUT;
          end else if (u_last) begin
            u_d     = '0;
            state_d = T_P2_RD;
          end else begin
            u_d     = u_q + IW'(1);
            state_d = T_P1_SEL;
          end
        end
      end
      T_P2_RD: begin
        if (live[u_q]) begin
          ram_re    = 1'b1;
          ram_raddr = u_q;
          state_d   = T_P2_LAT;
        end else if (u_last) begin
          class_d = CLASS_TARGET;
          state_d = T_OUT;
        end else begin
          u_d = u_q + IW'(1);
        end
      end
      T_P2_LAT: begin
        // keep only live partners above u
        nbr_d   = row & live & ~mask_le(u_q);
        v_d     = '0;
        state_d = T_P2_SEL;
      end
      T_P2_SEL: begin
        if (nbr_q[v_q]) begin
          cmd.start   = 1'b1;
          cmd.skip_en = 1'b1;
          cmd.lo      = u_q;
          cmd.hi      = v_q;
          state_d     = T_P2_WT;
        end else if (!v_last) begin
          v_d = v_q + IW'(1);
        end else if (u_last) begin
          class_d = CLASS_TARGET;
          state_d = T_OUT;
        end else begin
          u_d     = u_q + IW'(1);
          state_d = T_P2_RD;
        end
      end
      T_P2_WT: begin
        if (sts.done) begin
          if (sts.colorable) begin
            class_d = CLASS_EDGE_CRIT;
            state_d = T_OUT;
          end else if (!v_last) begin
            v_d     = v_q + IW'(1);
            state_d = T_P2_SEL;
          end else if (u_last) begin
            class_d = CLASS_TARGET;
            state_d = T_OUT;
          end else begin
            u_d     = u_q + IW'(1);
            state_d = T_P2_RD;
          end
        end
      end
      T_OUT: begin
        // drop the whole store for the next graph
        valid_d = '0;
        state_d = T_IDLE;
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      valid_q <= '0;
      vc_q    <= CW'(14);
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      if (vertex_count_we_i) vc_q <= vertex_count_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) rd_vld_q <= valid_q[ram_raddr];
    if (accept) begin
      a_q       <= vertex_a_i;
      b_q       <= vertex_b_i;
      last_q    <= last_edge_i;
      inrange_q <= ({1'b0, vertex_a_i} < 6'(NV)) && ({1'b0, vertex_b_i} < 6'(NV));
    end
    u_q     <= u_d;
    v_q     <= v_d;
    nbr_q   <= nbr_d;
    class_q <= class_d;
  end

  assign busy_o        = (state_q != T_IDLE);
  assign done_o        = (state_q == T_OUT);
  assign graph_class_o = class_q;

`ifndef SYNTH
  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("no return to idle after a result beat");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("accepted beat did not raise busy");
  a_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && sts.rd_en))
    else $error("row write collides with a search read");
  a_store_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (valid_q == '0))
    else $error("store not cleared after a result beat");
`endif

endmodule

@@ tb/sv/graph_three_color_criticality_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph_three_color_criticality_checker
// Watches the edge, configuration and class channels of the classifier.
// Keeps its own adjacency store and count and predicts the class of each
// graph. Compares every class beat with the oldest prediction.
// ----------------------------------------------------------------------------
module graph_three_color_criticality_checker (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   busy_i,
  input  logic [4:0]             vertex_a_i,
  input  logic [4:0]             vertex_b_i,
  input  logic                   last_edge_i,
  input  logic                   vertex_count_we_i,
  input  logic [gtc_pkg::CW-1:0] vertex_count_i,
  input  logic                   done_i,
  input  logic [1:0]             graph_class_i,
  output int                     fail_count_o,
  output int                     classes_owed_o
);
  import gtc_pkg::*;

  logic [31:0]   adj_rows [32];
  logic [CW-1:0] count_q;
  logic [1:0]    owed_fifo_q [4];
  logic [1:0]    owed_wr_q, owed_rd_q;
  int            owed_cnt_q;

  function automatic logic [31:0] active_set(logic [CW-1:0] vc);
    if (vc >= 6'd32) return '1;
    return (32'd1 << vc) - 32'd1;
  endfunction

  // Exhaustive backtracking 3-colouring of the vertices in live
  function automatic bit can_color(logic [31:0] rows [32], logic [31:0] live,
                                   bit skip, int lo, int hi);
    int          ord [32];
    logic [31:0] nb [32];
    int          tryc [33];
    int          col [32];
    logic [31:0] cmask [3];
    int          m;
    int          pos;
    bit          adv;
    m = 0;
    cmask[0] = '0; cmask[1] = '0; cmask[2] = '0;
    for (int v = 0; v < 32; v++) begin
      if (live[v]) begin
        ord[m] = v;
        nb[m]  = rows[v] & live & ~(32'd1 << v);
        if (skip && v == lo) nb[m][hi] = 1'b0;
        if (skip && v == hi) nb[m][lo] = 1'b0;
        m++;
      end
    end
    if (m == 0) return 1;
    pos = 0;
    tryc[0] = 0;
    forever begin
      if (pos == m) return 1;
      adv = 0;
      for (int c = tryc[pos]; c < 3; c++) begin
        if ((nb[pos] & cmask[c]) == '0) begin
          cmask[c][ord[pos]] = 1'b1;
          col[pos]  = c;
          tryc[pos] = c + 1;
          pos++;
          tryc[pos] = 0;
          adv = 1;
          break;
        end
      end
      if (!adv) begin
        if (pos == 0) return 0;
        pos--;
        cmask[col[pos]][ord[pos]] = 1'b0;
      end
    end
  endfunction

  function automatic logic [1:0] grade_graph(logic [31:0] rows [32], logic [CW-1:0] vc);
    logic [31:0] live;
    live = active_set(vc);
    if (can_color(rows, live, 0, 0, 0)) return CLASS_COLORABLE;
    for (int v = 0; v < 32; v++)
      if (live[v] && !can_color(rows, live & ~(32'd1 << v), 0, 0, 0)) return CLASS_NOT_CRIT;
    for (int u = 0; u < 32; u++) begin
      if (live[u]) begin
        for (int v = u + 1; v < 32; v++)
          if (rows[u][v] && live[v] && can_color(rows, live, 1, u, v)) return CLASS_EDGE_CRIT;
      end
    end
    return CLASS_TARGET;
  endfunction

  assign classes_owed_o = owed_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] rows_next [32];
    logic        owe;
    logic        settle;
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) adj_rows[i] <= '0;
      count_q      <= 6'd14;
      fail_count_o <= 0;
      owed_wr_q    <= '0;
      owed_rd_q    <= '0;
      owed_cnt_q   <= 0;
    end else begin
      owe    = 1'b0;
      settle = 1'b0;
      if (vertex_count_we_i) count_q <= vertex_count_i;
      if (start_i && !busy_i) begin
        rows_next = adj_rows;
        rows_next[vertex_a_i][vertex_b_i] = 1'b1;
        rows_next[vertex_b_i][vertex_a_i] = 1'b1;
        if (last_edge_i) begin
          owed_fifo_q[owed_wr_q] <= grade_graph(rows_next, count_q);
          owed_wr_q <= owed_wr_q + 2'd1;
          owe = 1'b1;
          for (int i = 0; i < 32; i++) adj_rows[i] <= '0;
        end else begin
          adj_rows <= rows_next;
        end
      end
      if (done_i) begin
        if (owed_cnt_q == 0) begin
          $error("graph_class: no class owed, got %0d", graph_class_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          if (graph_class_i !== owed_fifo_q[owed_rd_q]) begin
            $error("graph_class: expected %0d, actual %0d", owed_fifo_q[owed_rd_q],
                   graph_class_i);
            fail_count_o <= fail_count_o + 1;
          end
          owed_rd_q <= owed_rd_q + 2'd1;
          settle = 1'b1;
        end
      end
      owed_cnt_q <= owed_cnt_q + int'(owe) - int'(settle);
    end
  end

endmodule

@@ tb/sv/graph_three_color_criticality_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph_three_color_criticality_test
// Feeds edge beats in random bursts, steps the vertex count through its
// extremes between graphs, and leaves checking to the checker beside the
// block. Gives the verdict once every owed class has arrived.
// ----------------------------------------------------------------------------
module graph_three_color_criticality_test;
  import gtc_pkg::*;

  localparam int IDLE_LIMIT = 400000;   // cycles without any beat

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start_i = 1'b0;
  logic          busy_o;
  logic [4:0]    vertex_a_i = '0;
  logic [4:0]    vertex_b_i = '0;
  logic          last_edge_i = 1'b0;
  logic          vertex_count_we_i = 1'b0;
  logic [CW-1:0] vertex_count_i = '0;
  logic          done_o;
  logic [1:0]    graph_class_o;
  int            fail_count;
  int            classes_owed;
  int            idle_cycles = 0;
  int            burst_left = 0;
  int            edges_sent = 0;

  always #5 clk_i = ~clk_i;

  graph_three_color_criticality uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .vertex_a_i, .vertex_b_i, .last_edge_i,
    .vertex_count_we_i, .vertex_count_i, .done_o, .graph_class_o
  );

  graph_three_color_criticality_checker chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .vertex_a_i, .vertex_b_i,
    .last_edge_i, .vertex_count_we_i, .vertex_count_i, .done_i(done_o),
    .graph_class_i(graph_class_o), .fail_count_o(fail_count),
    .classes_owed_o(classes_owed)
  );

  // Watchdog: any beat on either channel restarts the count
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offer one edge beat and hold it until the block takes it. At the end
  // of a burst the task drops start_i for a gap first; else the next beat follows straight away.
  task automatic push_edge(input int a, input int b, input int last);
    if (burst_left == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(0, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    start_i     <= 1'b1;
    vertex_a_i  <= 5'(a);
    vertex_b_i  <= 5'(b);
    last_edge_i <= (last != 0);
    do @(posedge clk_i); while (busy_o);
    burst_left--;
    edges_sent++;
  endtask

  // Drain every owed class, let the block settle, then write the count
  task automatic load_count(input int vc);
    start_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (classes_owed != 0 || busy_o);
    repeat (8) @(posedge clk_i);
    vertex_count_we_i <= 1'b1;
    vertex_count_i    <= CW'(vc);
    @(posedge clk_i);
    vertex_count_we_i <= 1'b0;
    vertex_count_i    <= logic'($urandom_range(0, 1)) ? 6'h3f : 6'h00;
  endtask

  // Four vertices, all joined
  task automatic push_clique4(input int base, input int last);
    push_edge(base, base + 1, 0); push_edge(base, base + 2, 0);
    push_edge(base, base + 3, 0); push_edge(base + 1, base + 2, 0);
    push_edge(base + 1, base + 3, 0); push_edge(base + 2, base + 3, last);
  endtask

  // Random graph on n vertices, endpoints sometimes beyond the active range
  task automatic push_random_graph(input int n);
    int hi;
    int edges;
    hi = (n < 2) ? 1 : n - 1;
    if (n > 12) edges = $urandom_range(1, 18);
    else edges = $urandom_range(1, 3 * n + 2);
    // keep the clique near vertex 0 so the search fails early
    if (n > 12 && $urandom_range(0, 1)) push_clique4($urandom_range(0, 2), 0);
    for (int e = 0; e < edges; e++) begin
      if ($urandom_range(0, 9) == 0)
        push_edge($urandom_range(0, 31), $urandom_range(0, 31), int'(e == edges - 1));
      else
        push_edge($urandom_range(0, hi), $urandom_range(0, hi), int'(e == edges - 1));
    end
  endtask

  initial begin
    int n;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: triangle at reset count, self-loop, far endpoints
    push_edge(0, 1, 0); push_edge(1, 2, 0); push_edge(3, 3, 0);
    push_edge(31, 31, 0); push_edge(2, 0, 1);
    // Clique of four is edge-critical
    load_count(4);
    push_clique4(0, 1);
    // Empty graph and a lone vertex
    load_count(0);
    push_edge(0, 1, 1);
    load_count(1);
    push_edge(0, 0, 1);
    // Saturated count with a clique: deleting a vertex outside it keeps it stuck
    load_count(63);
    push_clique4(0, 1);
    load_count(32);
    push_edge(31, 0, 0); push_edge(16, 15, 1);

    // Random phases, mostly small counts
    while (edges_sent < 1650) begin
      case ($urandom_range(0, 11))
        0:       n = 0;
        1:       n = $urandom_range(1, 2);
        2:       n = ($urandom_range(0, 1)) ? 32 : 63;
        3:       n = $urandom_range(13, 31);
        default: n = $urandom_range(3, 9);
      endcase
      load_count(n);
      repeat ($urandom_range(1, 6)) push_random_graph(n > 32 ? 32 : n);
    end

    start_i <= 1'b0;
    do @(posedge clk_i); while (classes_owed != 0);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ graph_three_color_criticality.f @@
rtl/core/gtc_pkg.sv
rtl/core/gtc_ram.sv
rtl/core/gtc_search.sv
rtl/core/graph_three_color_criticality.sv
tb/sv/graph_three_color_criticality_checker.sv
tb/sv/graph_three_color_criticality_test.sv
